// ===== hw/rtl/faorb_pkg.sv =====
package faorb_pkg;

    localparam int LEN_W      = 32;
    localparam int CAP_W      = 17;
    localparam int PTR_W      = 16;
    localparam int FRAME_W    = 4;
    localparam int BYTE_W     = 8;
    localparam int TOTAL_W    = 64;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam int CAP_MAX             = 65536;
    localparam int STORE_DEPTH_DEFAULT = 65536;
    localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(4);

    localparam int REM_DIGIT_W = 4;
    localparam int REM_STEPS   = LEN_W / REM_DIGIT_W;
    localparam int REM_CNT_W   = $clog2(REM_STEPS);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE_START = 2'd0,
        FUNC_WRITE_BYTE  = 2'd1,
        FUNC_READ_START  = 2'd2,
        FUNC_READ_BYTE   = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY_BYTES = 1'd0,
        CFG_FRAME_BYTES    = 1'd1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CAP_GO,
        ST_CAP_WAIT,
        ST_WL_WAIT,
        ST_WCHK,
        ST_WS_WAIT,
        ST_WSUB,
        ST_WROOM,
        ST_WM_WAIT,
        ST_WDROP,
        ST_WAPPLY,
        ST_WFIN,
        ST_RW_WAIT,
        ST_RF_WAIT,
        ST_RMIN,
        ST_RFIN
    } state_t;

    typedef struct packed {
        func_t              func;
        logic [LEN_W-1:0]   length;
        logic [BYTE_W-1:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [CAP_W-1:0]   granted_length;
        logic [BYTE_W-1:0]  read_byte;
        logic [CAP_W-1:0]   queued_bytes;
        logic [TOTAL_W-1:0] dropped_bytes;
        logic [TOTAL_W-1:0] underrun_count;
    } result_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [PTR_W-1:0]  addr;
        logic [BYTE_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic               go;
        logic [LEN_W-1:0]   value;
        logic [FRAME_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic               done;
        logic [FRAME_W-1:0] remainder;
    } rem_rsp_t;

endpackage

// ===== hw/rtl/frame_aligned_overwrite_ring_buffer.sv =====
// Frame-aligned overwriting byte ring buffer.
// Commands enter on item when start is high and busy is low; func picks
// write start, write byte, read start or read byte. Every command that
// cfg_en does not cut off gives exactly one result beat on result, marked
// by done for one cycle; the receiver takes it unconditionally.
// Byte commands: result in the cycle after acceptance, one per cycle, with
// busy staying low, so bytes stream back to back through the store RAM.
// Start commands: busy while frame alignment runs through the shared
// remainder unit, 4 bits per cycle. The result beat comes in the same
// cycle that busy drops; a write start with zero length or capacity 0
// answers without raising busy.
// Configuration: cfg_en writes cfg_data to register cfg_index (0 capacity,
// 1 frame size) at once, clears pointers and counts, then busy stays high
// while the effective capacity is aligned.
// Reset: capacity 0 (disabled), frame size 4, all pointers and counts zero.
// The store keeps its contents across configuration writes.
module frame_aligned_overwrite_ring_buffer #(
    parameter int STORE_DEPTH = faorb_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  faorb_pkg::item_t                      item,
    output logic                                  busy,
    output logic                                  done,
    output faorb_pkg::result_t                    result,
    input  logic                                  cfg_en,
    input  logic [faorb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [faorb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import faorb_pkg::*;

    localparam int MEM_DEPTH = (STORE_DEPTH < CAP_MAX) ? STORE_DEPTH : CAP_MAX;

    mem_req_t          mem_req;
    logic [BYTE_W-1:0] mem_rdata;
    rem_req_t          rem_req;
    rem_rsp_t          rem_rsp;

    faorb_ctrl #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .rem_req   (rem_req),
        .rem_rsp   (rem_rsp)
    );

    faorb_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    faorb_store #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    a_byte_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !cfg_en &&
         (item.func == FUNC_WRITE_BYTE || item.func == FUNC_READ_BYTE)) |=> done)
        else $error("byte command without result beat");

    a_read_byte_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result.read_byte != '0) |-> done)
        else $error("read byte outside a result beat");

    a_grant_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result.granted_length != '0) |-> done)
        else $error("granted length outside a result beat");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.queued_bytes <= CAP_W'(CAP_MAX))
        else $error("fill beyond store limit");

endmodule

// ===== hw/rtl/faorb_rem.sv =====
module faorb_rem (
    input  logic                clk,
    input  logic                rst_n,
    input  faorb_pkg::rem_req_t req,
    output faorb_pkg::rem_rsp_t rsp
);
    import faorb_pkg::*;

    logic [LEN_W-1:0]     val_reg;
    logic [LEN_W-1:0]     val_next;
    logic [FRAME_W-1:0]   r_reg;
    logic [FRAME_W-1:0]   r_next;
    logic [FRAME_W-1:0]   r_step;
    logic [FRAME_W:0]     trial;
    logic [REM_CNT_W-1:0] cnt_reg;
    logic [REM_CNT_W-1:0] cnt_next;
    logic                 run_reg;
    logic                 run_next;
    logic                 done_reg;
    logic                 done_next;

    // one remainder digit per step, most significant bit first
    always_comb
    begin
        r_step = r_reg;
        trial  = '0;
        for (int i = 0; i < REM_DIGIT_W; i++)
        begin
            trial = {r_step, val_reg[LEN_W-1-i]};
            if (trial >= {1'b0, req.divisor})
            begin
                trial = trial - {1'b0, req.divisor};
            end
            r_step = trial[FRAME_W-1:0];
        end
    end

    always_comb
    begin
        val_next  = val_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            val_next = req.value;
            r_next   = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            val_next = val_reg << REM_DIGIT_W;
            r_next   = r_step;
            cnt_next = cnt_reg + REM_CNT_W'(1);
            if (cnt_reg == REM_CNT_W'(REM_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        r_reg   <= r_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = (req.divisor == '0) ? '0 : r_reg;

endmodule

// ===== hw/rtl/faorb_store.sv =====
module faorb_store #(
    parameter int MEM_DEPTH = faorb_pkg::CAP_MAX
) (
    input  logic                                  clk,
    input  faorb_pkg::mem_req_t                   req,
    output logic [faorb_pkg::BYTE_W-1:0]          rdata
);
    import faorb_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    logic [BYTE_W-1:0] mem [0:MEM_DEPTH-1];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/faorb_ctrl.sv =====
module faorb_ctrl #(
    parameter int MEM_DEPTH = faorb_pkg::CAP_MAX
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  faorb_pkg::item_t                      item,
    output logic                                  busy,
    output logic                                  done,
    output faorb_pkg::result_t                    result,
    input  logic                                  cfg_en,
    input  logic [faorb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [faorb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output faorb_pkg::mem_req_t                   mem_req,
    input  logic [faorb_pkg::BYTE_W-1:0]          mem_rdata,
    output faorb_pkg::rem_req_t                   rem_req,
    input  faorb_pkg::rem_rsp_t                   rem_rsp
);
    import faorb_pkg::*;

    localparam int CAP_LIMIT_INT = (MEM_DEPTH < CAP_MAX) ? MEM_DEPTH : CAP_MAX;
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(CAP_LIMIT_INT);

    state_t               state_reg, state_next;
    logic                 done_reg, done_next;
    logic                 rb_sel_reg, rb_sel_next;
    logic [CAP_W-1:0]     granted_reg, granted_next;
    logic [CAP_W-1:0]     capacity_reg, capacity_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [CAP_W-1:0]     cap_eff_reg, cap_eff_next;
    logic [PTR_W-1:0]     rp_reg, rp_next;
    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [CAP_W-1:0]     fill_reg, fill_next;
    logic [TOTAL_W-1:0]   dropped_reg, dropped_next;
    logic [TOTAL_W-1:0]   underrun_reg, underrun_next;
    logic [LEN_W-1:0]     cidx_reg, cidx_next;
    logic [LEN_W-1:0]     cskip_reg, cskip_next;
    logic [LEN_W:0]       cend_reg, cend_next;
    logic [CAP_W-1:0]     rgrant_reg, rgrant_next;
    logic [CAP_W-1:0]     ridx_reg, ridx_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     skip_reg, skip_next;
    logic [CAP_W-1:0]     miss_reg, miss_next;

    logic                 accept;
    logic                 cap_zero;
    logic [CAP_W-1:0]     cap_min;
    logic [FRAME_W-1:0]   rem;
    logic [CAP_W-1:0]     wp_plus;
    logic [CAP_W-1:0]     rp_plus;
    logic [PTR_W-1:0]     wp_inc;
    logic [PTR_W-1:0]     rp_inc;
    logic                 in_chunk;
    logic [CAP_W:0]       room_sum;
    logic [CAP_W:0]       miss_diff;
    logic                 miss_pos;
    logic [CAP_W-1:0]     drop_n;
    logic [CAP_W:0]       drop_sum;
    logic [CAP_W:0]       drop_wrap;
    logic [PTR_W-1:0]     rp_drop;
    logic [CAP_W-1:0]     miss_up;
    logic                 rd_fill_go;
    logic [LEN_W-1:0]     len_over;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign cap_zero = (cap_eff_reg == '0);
    assign cap_min  = (capacity_reg > CAP_LIMIT) ? CAP_LIMIT : capacity_reg;
    assign rem      = rem_rsp.remainder;

    assign wp_plus = {1'b0, wp_reg} + CAP_W'(1);
    assign rp_plus = {1'b0, rp_reg} + CAP_W'(1);
    assign wp_inc  = (wp_plus == cap_eff_reg) ? '0 : wp_plus[PTR_W-1:0];
    assign rp_inc  = (rp_plus == cap_eff_reg) ? '0 : rp_plus[PTR_W-1:0];

    assign in_chunk = (cidx_reg >= cskip_reg) && ({1'b0, cidx_reg} < cend_reg);

    assign room_sum  = {1'b0, len_reg[CAP_W-1:0]} + {1'b0, fill_reg};
    assign miss_pos  = room_sum > {1'b0, cap_eff_reg};
    assign miss_diff = room_sum - {1'b0, cap_eff_reg};

    assign drop_n    = (state_reg == ST_WCHK) ? fill_reg : miss_reg;
    assign drop_sum  = {2'b00, rp_reg} + {1'b0, drop_n};
    assign drop_wrap = drop_sum - {1'b0, cap_eff_reg};
    assign rp_drop   = (drop_sum >= {1'b0, cap_eff_reg}) ? drop_wrap[PTR_W-1:0]
                                                         : drop_sum[PTR_W-1:0];

    assign miss_up    = (rem == '0) ? miss_reg
                                    : miss_reg + CAP_W'(frame_reg - rem);
    assign rd_fill_go = !cap_zero && (len_reg != '0) && (fill_reg != '0);
    assign len_over   = len_reg - LEN_W'(cap_eff_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.func == FUNC_WRITE_START && !cap_zero && item.length != '0)
                    begin
                        state_next = ST_WL_WAIT;
                    end
                    else if (item.func == FUNC_READ_START)
                    begin
                        state_next = ST_RW_WAIT;
                    end
                end
            end
            ST_CAP_GO:   state_next = ST_CAP_WAIT;
            ST_CAP_WAIT: if (rem_rsp.done) state_next = ST_IDLE;
            ST_WL_WAIT:  if (rem_rsp.done) state_next = ST_WCHK;
            ST_WCHK:
            begin
                if (len_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_reg > LEN_W'(cap_eff_reg))
                begin
                    state_next = ST_WS_WAIT;
                end
                else
                begin
                    state_next = ST_WROOM;
                end
            end
            ST_WS_WAIT:  if (rem_rsp.done) state_next = ST_WSUB;
            ST_WSUB:     state_next = ST_WROOM;
            ST_WROOM:    state_next = miss_pos ? ST_WM_WAIT : ST_WFIN;
            ST_WM_WAIT:  if (rem_rsp.done) state_next = ST_WDROP;
            ST_WDROP:    state_next = ST_WAPPLY;
            ST_WAPPLY:   state_next = ST_WFIN;
            ST_WFIN:     state_next = ST_IDLE;
            ST_RW_WAIT:
            begin
                if (rem_rsp.done)
                begin
                    state_next = rd_fill_go ? ST_RF_WAIT : ST_RFIN;
                end
            end
            ST_RF_WAIT:  if (rem_rsp.done) state_next = ST_RMIN;
            ST_RMIN:     state_next = ST_RFIN;
            ST_RFIN:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
        if (cfg_en)
        begin
            state_next = ST_CAP_GO;
        end
    end

    always_comb
    begin
        done_next     = 1'b0;
        rb_sel_next   = 1'b0;
        granted_next  = '0;
        capacity_next = capacity_reg;
        frame_next    = frame_reg;
        cap_eff_next  = cap_eff_reg;
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        dropped_next  = dropped_reg;
        underrun_next = underrun_reg;
        cidx_next     = cidx_reg;
        cskip_next    = cskip_reg;
        cend_next     = cend_reg;
        rgrant_next   = rgrant_reg;
        ridx_next     = ridx_reg;
        len_next      = len_reg;
        skip_next     = skip_reg;
        miss_next     = miss_reg;

        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.addr  = wp_reg;
        mem_req.wdata = item.data_byte;

        rem_req.go      = 1'b0;
        rem_req.value   = len_reg;
        rem_req.divisor = frame_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.func)
                        FUNC_WRITE_START:
                        begin
                            cidx_next  = '0;
                            cskip_next = '0;
                            cend_next  = '0;
                            skip_next  = '0;
                            len_next   = item.length;
                            if (cap_zero || item.length == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rem_req.go    = 1'b1;
                                rem_req.value = item.length;
                            end
                        end
                        FUNC_WRITE_BYTE:
                        begin
                            done_next = 1'b1;
                            if (cidx_reg != '1)
                            begin
                                cidx_next = cidx_reg + LEN_W'(1);
                            end
                            if (in_chunk && !cap_zero && fill_reg < cap_eff_reg)
                            begin
                                mem_req.we   = 1'b1;
                                mem_req.addr = wp_reg;
                                wp_next      = wp_inc;
                                fill_next    = fill_reg + CAP_W'(1);
                            end
                        end
                        FUNC_READ_START:
                        begin
                            len_next      = item.length;
                            rem_req.go    = 1'b1;
                            rem_req.value = item.length;
                        end
                        FUNC_READ_BYTE:
                        begin
                            done_next = 1'b1;
                            if (ridx_reg < rgrant_reg)
                            begin
                                ridx_next = ridx_reg + CAP_W'(1);
                                if (fill_reg != '0 && !cap_zero)
                                begin
                                    mem_req.re   = 1'b1;
                                    mem_req.addr = rp_reg;
                                    rp_next      = rp_inc;
                                    fill_next    = fill_reg - CAP_W'(1);
                                    rb_sel_next  = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_CAP_GO:
            begin
                rem_req.go    = 1'b1;
                rem_req.value = LEN_W'(cap_min);
            end
            ST_CAP_WAIT:
            begin
                if (rem_rsp.done)
                begin
                    cap_eff_next = cap_min - CAP_W'(rem);
                end
            end
            ST_WL_WAIT:
            begin
                if (rem_rsp.done)
                begin
                    len_next = len_reg - LEN_W'(rem);
                end
            end
            ST_WCHK:
            begin
                if (len_reg == '0)
                begin
                    done_next = 1'b1;
                end
                else if (len_reg > LEN_W'(cap_eff_reg))
                begin
                    skip_next     = len_over;
                    rem_req.go    = 1'b1;
                    rem_req.value = len_over;
                    rp_next       = rp_drop;
                    fill_next     = '0;
                    dropped_next  = dropped_reg + TOTAL_W'(fill_reg);
                end
            end
            ST_WS_WAIT:
            begin
                if (rem_rsp.done)
                begin
                    skip_next = skip_reg - LEN_W'(rem);
                end
            end
            ST_WSUB:
            begin
                len_next = len_reg - skip_reg;
            end
            ST_WROOM:
            begin
                if (miss_pos)
                begin
                    miss_next     = miss_diff[CAP_W-1:0];
                    rem_req.go    = 1'b1;
                    rem_req.value = LEN_W'(miss_diff[CAP_W-1:0]);
                end
            end
            ST_WM_WAIT:
            begin
                if (rem_rsp.done)
                begin
                    miss_next = miss_up;
                end
            end
            ST_WDROP:
            begin
                if (miss_reg > fill_reg)
                begin
                    miss_next = fill_reg;
                end
            end
            ST_WAPPLY:
            begin
                rp_next      = rp_drop;
                fill_next    = fill_reg - miss_reg;
                dropped_next = dropped_reg + TOTAL_W'(miss_reg);
            end
            ST_WFIN:
            begin
                cskip_next   = skip_reg;
                cend_next    = {1'b0, skip_reg} + {1'b0, len_reg};
                granted_next = len_reg[CAP_W-1:0];
                done_next    = 1'b1;
            end
            ST_RW_WAIT:
            begin
                if (rem_rsp.done)
                begin
                    len_next = len_reg - LEN_W'(rem);
                    if (rd_fill_go)
                    begin
                        rem_req.go    = 1'b1;
                        rem_req.value = LEN_W'(fill_reg);
                    end
                    else
                    begin
                        rgrant_next = '0;
                    end
                end
            end
            ST_RF_WAIT:
            begin
                if (rem_rsp.done)
                begin
                    rgrant_next = fill_reg - CAP_W'(rem);
                end
            end
            ST_RMIN:
            begin
                if (len_reg < LEN_W'(rgrant_reg))
                begin
                    rgrant_next = len_reg[CAP_W-1:0];
                end
            end
            ST_RFIN:
            begin
                if (LEN_W'(rgrant_reg) < len_reg)
                begin
                    underrun_next = underrun_reg + TOTAL_W'(1);
                end
                ridx_next    = '0;
                granted_next = rgrant_reg;
                done_next    = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase

        if (cfg_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_CAPACITY_BYTES: capacity_next = cfg_data[CAP_W-1:0];
                CFG_FRAME_BYTES:    frame_next    = cfg_data[FRAME_W-1:0];
            endcase
            done_next     = 1'b0;
            rb_sel_next   = 1'b0;
            granted_next  = '0;
            mem_req.we    = 1'b0;
            mem_req.re    = 1'b0;
            rp_next       = '0;
            wp_next       = '0;
            fill_next     = '0;
            dropped_next  = '0;
            underrun_next = '0;
            cidx_next     = '0;
            cskip_next    = '0;
            cend_next     = '0;
            rgrant_next   = '0;
            ridx_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            rb_sel_reg   <= 1'b0;
            granted_reg  <= '0;
            capacity_reg <= '0;
            frame_reg    <= FRAME_RESET;
            cap_eff_reg  <= '0;
            rp_reg       <= '0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            dropped_reg  <= '0;
            underrun_reg <= '0;
            cidx_reg     <= '0;
            cskip_reg    <= '0;
            cend_reg     <= '0;
            rgrant_reg   <= '0;
            ridx_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            rb_sel_reg   <= rb_sel_next;
            granted_reg  <= granted_next;
            capacity_reg <= capacity_next;
            frame_reg    <= frame_next;
            cap_eff_reg  <= cap_eff_next;
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            dropped_reg  <= dropped_next;
            underrun_reg <= underrun_next;
            cidx_reg     <= cidx_next;
            cskip_reg    <= cskip_next;
            cend_reg     <= cend_next;
            rgrant_reg   <= rgrant_next;
            ridx_reg     <= ridx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        skip_reg <= skip_next;
        miss_reg <= miss_next;
    end

    assign done                  = done_reg;
    assign result.granted_length = granted_reg;
    assign result.read_byte      = rb_sel_reg ? mem_rdata : '0;
    assign result.queued_bytes   = fill_reg;
    assign result.dropped_bytes  = dropped_reg;
    assign result.underrun_count = underrun_reg;

endmodule
